/* src/power_meter_frame_receiver_core_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the energy meter frame receiver
// Shared forms of the clocked assertions used in the RTL, with and without reset.
// ----------------------------------------------------------------------------
`ifndef POWER_METER_FRAME_RECEIVER_CORE_DEFINES_SVH
`define POWER_METER_FRAME_RECEIVER_CORE_DEFINES_SVH

// Checks an implication on every rising clock edge outside reset.
`define PMFR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define PMFR_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* src/pmfr_pkg.sv */
// ----------------------------------------------------------------------------
// Energy meter frame receiver package
// Types and constants shared by the frame receiver modules.
// ----------------------------------------------------------------------------
package pmfr_pkg;

   localparam int FRAME_LEN = 24;
   localparam int SUM_LAST = 22;
   localparam int DIVIDEND_BITS = 48;
   localparam int PRODUCT_BITS = 64;
   localparam int GAIN_BITS = 24;
   localparam int VALUE_BITS = 32;
   localparam int SUM_BITS = 48;
   localparam int FIELD_BITS = 24;
   localparam int Q_BITS = 16;

   localparam logic [7:0] HEADER_BYTE = 8'h55;
   localparam logic [3:0] HEADER_NIBBLE = 4'hF;
   localparam logic [7:0] MARKER_BYTE = 8'h5A;
   localparam int FLAG_POS = 20;
   localparam int FLAG_VOLTS_BIT = 6;
   localparam logic [GAIN_BITS-1:0] GAIN_RESET = 24'h010000;

   typedef enum logic [1:0] {
      REG_GAIN_VOLTAGE = 2'd0,
      REG_GAIN_CURRENT = 2'd1,
      REG_GAIN_POWER   = 2'd2,
      REG_NONE         = 2'd3
   } reg_index_type;

   typedef enum logic {
      OP_DIV = 1'b0,
      OP_MUL = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_DIV,
      ST_MUL,
      ST_NEXT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic   start;
      op_type op;
   } unit_ctl_type;

   function automatic logic is_header(input logic [7:0] b);
      is_header = (b == HEADER_BYTE) || (b[7:4] == HEADER_NIBBLE);
   endfunction

endpackage

/* src/pmfr_if.sv */
// ----------------------------------------------------------------------------
// Energy meter frame receiver channels
// Valid/ready channels for the request and response items.
// ----------------------------------------------------------------------------
interface pmfr_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] rx_byte;

   modport source (output valid, output mode, output rx_byte, input ready);
   modport sink (input valid, input mode, input rx_byte, output ready);
endinterface

interface pmfr_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [31:0] volts;
   logic [31:0] amps;
   logic [31:0] watts;
   logic        ok;

   modport source (output valid, output kind, output volts, output amps, output watts,
                   output ok, input ready);
   modport sink (input valid, input kind, input volts, input amps, input watts,
                 input ok, output ready);
endinterface

/* src/pmfr_unit.sv */
// ----------------------------------------------------------------------------
// Shared arithmetic unit
// Restoring divider (one quotient bit per cycle) and shift-add multiplier
// (one multiplier bit per cycle) sharing one sequencing counter.
// ----------------------------------------------------------------------------
module pmfr_unit #(
   parameter int DIV_BITS = 24
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  pmfr_pkg::unit_ctl_type                 ctl,
   input  logic [pmfr_pkg::DIVIDEND_BITS-1:0]     operand_a,
   input  logic [DIV_BITS-1:0]                    operand_b,
   output logic                                   done,
   output logic [pmfr_pkg::PRODUCT_BITS-1:0]      result
);
   import pmfr_pkg::*;

   localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   op_type                     op_ff, op_in;
   logic [CNT_BITS-1:0]        cnt_ff, cnt_in;
   logic [DIV_BITS:0]          rem_ff, rem_in;
   logic [DIVIDEND_BITS-1:0]   quo_ff, quo_in;
   logic [DIV_BITS-1:0]        dvs_ff, dvs_in;
   logic [PRODUCT_BITS-1:0]    acc_ff, acc_in;
   logic [PRODUCT_BITS-1:0]    mcand_ff, mcand_in;
   logic [GAIN_BITS-1:0]       mplier_ff, mplier_in;
   logic [DIV_BITS:0]          shifted;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      op_ff <= op_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      acc_ff <= acc_in;
      mcand_ff <= mcand_in;
      mplier_ff <= mplier_in;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in = op_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      dvs_in = dvs_ff;
      acc_in = acc_ff;
      mcand_in = mcand_ff;
      mplier_in = mplier_ff;
      shifted = {rem_ff[DIV_BITS-1:0], quo_ff[DIVIDEND_BITS-1]};
      if (ctl.start) begin
         busy_in = 1'b1;
         op_in = ctl.op;
         rem_in = '0;
         quo_in = operand_a;
         dvs_in = operand_b;
         acc_in = '0;
         mcand_in = PRODUCT_BITS'(operand_a);
         mplier_in = operand_b[GAIN_BITS-1:0];
         cnt_in = (ctl.op == OP_DIV) ? CNT_BITS'(DIVIDEND_BITS) : CNT_BITS'(GAIN_BITS);
      end else if (busy_ff) begin
         if (op_ff == OP_DIV) begin
            if (shifted >= {1'b0, dvs_ff}) begin
               rem_in = shifted - {1'b0, dvs_ff};
               quo_in = {quo_ff[DIVIDEND_BITS-2:0], 1'b1};
            end else begin
               rem_in = shifted;
               quo_in = {quo_ff[DIVIDEND_BITS-2:0], 1'b0};
            end
         end else begin
            if (mplier_ff[0]) begin
               acc_in = acc_ff + mcand_ff;
            end
            mcand_in = {mcand_ff[PRODUCT_BITS-2:0], 1'b0};
            mplier_in = {1'b0, mplier_ff[GAIN_BITS-1:1]};
         end
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (cnt_ff == CNT_BITS'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   assign done = done_ff;
   assign result = (op_ff == OP_DIV) ? PRODUCT_BITS'(quo_ff) : acc_ff;

endmodule

/* src/power_meter_frame_receiver_core.sv */
// ----------------------------------------------------------------------------
// Energy meter frame receiver
// Frame parser, calibrated ratio computation and averaging for an energy
// metering chip's serial stream.
// ----------------------------------------------------------------------------
// A byte that completes a good frame starts three quantities on one shared
// unit: each one whose flag is set and whose cycle field is nonzero takes a
// division and then a multiplication; the others give zero. An average
// request takes three divisions, or none when the count is zero.
// Requests are not taken while the unit is busy or a result waits for a free
// output register.
module power_meter_frame_receiver_core #(
   parameter int COUNT_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   pmfr_req_if.sink    req_bus,
   pmfr_rsp_if.source  rsp_bus,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);
   import pmfr_pkg::*;

   `include "power_meter_frame_receiver_core_defines.svh"

   localparam int DIV_BITS = (COUNT_BITS > FIELD_BITS) ? COUNT_BITS : FIELD_BITS;

   state_type               state_ff, state_in;
   logic [7:0]              frame_ff [FRAME_LEN];
   logic                    frame_we;
   logic [4:0]              pos_ff, pos_in;
   logic [7:0]              chk_ff, chk_in;
   logic [SUM_BITS-1:0]     sum_ff [3];
   logic [SUM_BITS-1:0]     sum_in [3];
   logic [COUNT_BITS-1:0]   count_ff, count_in;
   logic [GAIN_BITS-1:0]    gain_ff [3];
   logic [VALUE_BITS-1:0]   res_ff [3];
   logic [VALUE_BITS-1:0]   res_in [3];
   logic [1:0]              idx_ff, idx_in;
   logic                    avg_ff, avg_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic                    kind_ff, kind_in;
   logic                    ok_ff, ok_in;
   logic                    rsp_ok_ff;
   logic [VALUE_BITS-1:0]   out_ff [3];
   logic                    load_out;
   logic                    req_take;
   logic                    cfg_write;
   reg_index_type           cfg_index;
   logic [FIELD_BITS-1:0]   coef [3];
   logic [FIELD_BITS-1:0]   cyc [3];
   logic                    flag [3];
   unit_ctl_type            unit_ctl;
   logic [DIVIDEND_BITS-1:0] unit_a;
   logic [DIV_BITS-1:0]     unit_b;
   logic                    unit_done;
   logic [PRODUCT_BITS-1:0] unit_result;
   logic [SUM_BITS:0]       sum_wide [3];

   pmfr_unit #(.DIV_BITS(DIV_BITS)) u_unit (
      .clock     (clock),
      .reset     (reset),
      .ctl       (unit_ctl),
      .operand_a (unit_a),
      .operand_b (unit_b),
      .done      (unit_done),
      .result    (unit_result)
   );

   assign cfg_write = psel && penable && pwrite;
   assign cfg_index = reg_index_type'(paddr[3:2]);
   assign pready = 1'b1;

   always_comb begin
      prdata = '0;
      unique case (cfg_index)
         REG_GAIN_VOLTAGE: prdata = 32'(gain_ff[0]);
         REG_GAIN_CURRENT: prdata = 32'(gain_ff[1]);
         REG_GAIN_POWER:   prdata = 32'(gain_ff[2]);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff[0] <= GAIN_RESET;
         gain_ff[1] <= GAIN_RESET;
         gain_ff[2] <= GAIN_RESET;
      end else if (cfg_write) begin
         unique case (cfg_index)
            REG_GAIN_VOLTAGE: gain_ff[0] <= pwdata[GAIN_BITS-1:0];
            REG_GAIN_CURRENT: gain_ff[1] <= pwdata[GAIN_BITS-1:0];
            REG_GAIN_POWER:   gain_ff[2] <= pwdata[GAIN_BITS-1:0];
            default:          ;
         endcase
      end
   end

   for (genvar g = 0; g < 3; g++) begin : g_field
      assign coef[g] = {frame_ff[2 + 6*g], frame_ff[3 + 6*g], frame_ff[4 + 6*g]};
      assign cyc[g] = {frame_ff[5 + 6*g], frame_ff[6 + 6*g], frame_ff[7 + 6*g]};
      assign flag[g] = frame_ff[FLAG_POS][FLAG_VOLTS_BIT - g];
      assign sum_wide[g] = {1'b0, sum_ff[g]} + (SUM_BITS + 1)'(res_ff[g]);
   end

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_take = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pos_ff <= '0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int k = 0; k < 3; k++) begin
            sum_ff[k] <= '0;
         end
      end else begin
         state_ff <= state_in;
         pos_ff <= pos_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int k = 0; k < 3; k++) begin
            sum_ff[k] <= sum_in[k];
         end
      end
      chk_ff <= chk_in;
      idx_ff <= idx_in;
      avg_ff <= avg_in;
      kind_ff <= kind_in;
      ok_ff <= ok_in;
      if (load_out) begin
         rsp_ok_ff <= ok_ff;
      end
      for (int k = 0; k < 3; k++) begin
         res_ff[k] <= res_in[k];
         if (load_out) begin
            out_ff[k] <= res_ff[k];
         end
      end
      if (frame_we) begin
         frame_ff[pos_ff] <= req_bus.rx_byte;
      end
   end

   always_comb begin
      state_in = state_ff;
      pos_in = pos_ff;
      chk_in = chk_ff;
      count_in = count_ff;
      idx_in = idx_ff;
      avg_in = avg_ff;
      kind_in = kind_ff;
      ok_in = ok_ff;
      frame_we = 1'b0;
      load_out = 1'b0;
      unit_ctl = '{start: 1'b0, op: OP_DIV};
      unit_a = '0;
      unit_b = '0;
      for (int k = 0; k < 3; k++) begin
         sum_in[k] = sum_ff[k];
         res_in[k] = res_ff[k];
      end
      rsp_valid_in = rsp_bus.ready ? 1'b0 : rsp_valid_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take && req_bus.mode) begin
               avg_in = 1'b1;
               idx_in = '0;
               if (count_ff == '0) begin
                  ok_in = 1'b0;
                  for (int k = 0; k < 3; k++) begin
                     res_in[k] = '0;
                  end
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_SETUP;
               end
            end else if (req_take) begin
               priority if (pos_ff == 5'd0) begin
                  if (is_header(req_bus.rx_byte)) begin
                     frame_we = 1'b1;
                     pos_in = 5'd1;
                  end
               end else if (pos_ff == 5'd1) begin
                  if (req_bus.rx_byte == MARKER_BYTE) begin
                     frame_we = 1'b1;
                     pos_in = 5'd2;
                  end else if (!is_header(req_bus.rx_byte)) begin
                     pos_in = 5'd0;
                  end
               end else if (pos_ff == 5'(FRAME_LEN - 1)) begin
                  frame_we = 1'b1;
                  pos_in = 5'd0;
                  if (chk_ff == req_bus.rx_byte) begin
                     avg_in = 1'b0;
                     idx_in = '0;
                     state_in = ST_SETUP;
                  end
               end else if (pos_ff < 5'(FRAME_LEN - 1)) begin
                  frame_we = 1'b1;
                  pos_in = pos_ff + 5'd1;
                  chk_in = (pos_ff == 5'd2) ? req_bus.rx_byte : chk_ff + req_bus.rx_byte;
               end else begin
                  pos_in = 5'd0;
               end
            end
         end
         ST_SETUP: begin
            if (avg_ff) begin
               unit_ctl = '{start: 1'b1, op: OP_DIV};
               unit_a = sum_ff[idx_ff];
               unit_b = DIV_BITS'(count_ff);
               state_in = ST_DIV;
            end else if (flag[idx_ff] && (cyc[idx_ff] != '0)) begin
               unit_ctl = '{start: 1'b1, op: OP_DIV};
               unit_a = DIVIDEND_BITS'({coef[idx_ff], 16'h0000});
               unit_b = DIV_BITS'(cyc[idx_ff]);
               state_in = ST_DIV;
            end else begin
               res_in[idx_ff] = '0;
               state_in = ST_NEXT;
            end
         end
         ST_DIV: begin
            if (unit_done) begin
               if (avg_ff) begin
                  res_in[idx_ff] = (|unit_result[DIVIDEND_BITS-1:VALUE_BITS]) ?
                                   '1 : unit_result[VALUE_BITS-1:0];
                  state_in = ST_NEXT;
               end else begin
                  unit_ctl = '{start: 1'b1, op: OP_MUL};
                  unit_a = unit_result[DIVIDEND_BITS-1:0];
                  unit_b = DIV_BITS'(gain_ff[idx_ff]);
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            if (unit_done) begin
               res_in[idx_ff] = (|unit_result[PRODUCT_BITS-1:VALUE_BITS+Q_BITS]) ?
                                '1 : unit_result[VALUE_BITS+Q_BITS-1:Q_BITS];
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            if (idx_ff == 2'd2) begin
               ok_in = 1'b1;
               state_in = ST_EMIT;
               if (avg_ff) begin
                  count_in = '0;
                  for (int k = 0; k < 3; k++) begin
                     sum_in[k] = '0;
                  end
               end else if (count_ff != '1) begin
                  count_in = count_ff + COUNT_BITS'(1);
                  for (int k = 0; k < 3; k++) begin
                     sum_in[k] = sum_wide[k][SUM_BITS] ? '1 : sum_wide[k][SUM_BITS-1:0];
                  end
               end
            end else begin
               idx_in = idx_ff + 2'd1;
               state_in = ST_SETUP;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               load_out = 1'b1;
               kind_in = avg_ff;
               rsp_valid_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.kind = kind_ff;
   assign rsp_bus.ok = rsp_ok_ff;
   assign rsp_bus.volts = out_ff[0];
   assign rsp_bus.amps = out_ff[1];
   assign rsp_bus.watts = out_ff[2];

   `PMFR_ASSERT(a_done_in_wait, clock, reset, unit_done |-> (state_ff == ST_DIV || state_ff == ST_MUL), "unit finished outside a wait state")
   `PMFR_ASSERT(a_pos_range, clock, reset, pos_ff < 5'(FRAME_LEN), "byte position out of range")
   `PMFR_ASSERT(a_rsp_from_emit, clock, reset, $rose(rsp_valid_ff) |-> $past(state_ff) == ST_EMIT, "response raised outside emit")
   `PMFR_ASSERT(a_avg_clears, clock, reset, (state_ff == ST_NEXT && avg_ff && idx_ff == 2'd2) |=> count_ff == '0, "average did not clear the count")

endmodule
